[rtl/dcmd_pkg.sv]
package dcmd_pkg;

  // Motor drive codes for a two-pin bidirectional motor
  typedef enum logic [1:0] {
    DRIVE_STOP = 2'd0,
    DRIVE_LOW  = 2'd1,
    DRIVE_HIGH = 2'd2
  } drive_e;

  localparam int unsigned AddrWidth = 9;
  localparam int unsigned SlotWidth = 10;

  // One received slot byte with its break flag
  typedef struct packed {
    logic [7:0] rx_byte;
    logic       break_seen;
  } in_t;

  // Output levels after the byte has been applied
  typedef struct packed {
    logic [1:0] motor1_drive;
    logic [1:0] motor2_drive;
    logic [1:0] motor3_drive;
    logic       single_motor_on;
    logic       in_frame_light;
  } out_t;

  // Handshake status of the input register toward the rest of the block
  typedef struct packed {
    logic valid;
    logic advance;
  } in_ctrl_t;

endpackage

[rtl/dcmd_in_stage.sv]
module dcmd_in_stage (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  dcmd_pkg::in_t     in_data_i,
  input  logic              out_room_i,
  output dcmd_pkg::in_ctrl_t ctrl_o,
  output dcmd_pkg::in_t     item_o
);

  logic          valid_q, valid_d;
  dcmd_pkg::in_t item_q;
  logic          advance;
  logic          take;

  // Item moves on when the result register has room
  assign advance    = valid_q & out_room_i;
  assign in_ready_o = ~valid_q | advance;
  assign take       = in_valid_i & in_ready_o;

  always_comb begin
    valid_d = valid_q;
    if (take) begin
      valid_d = 1'b1;
    end else if (advance) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Payload register, no reset needed
  always_ff @(posedge clk_i) begin
    if (take) begin
      item_q <= in_data_i;
    end
  end

  assign ctrl_o.valid   = valid_q;
  assign ctrl_o.advance = advance;
  assign item_o         = item_q;

endmodule

[rtl/dcmd_decode.sv]
module dcmd_decode (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [dcmd_pkg::AddrWidth-1:0]     cfg_wdata_i,
  input  logic                               advance_i,
  input  dcmd_pkg::in_t                      item_i,
  output dcmd_pkg::out_t                     result_o
);

  localparam logic [7:0] LowMin    = 8'd15;
  localparam logic [7:0] LowLim    = 8'd95;
  localparam logic [7:0] HighMin   = 8'd175;
  localparam logic [7:0] SingleMin = 8'd128;
  localparam logic [dcmd_pkg::SlotWidth-1:0] SlotMax = '1;
  localparam logic [dcmd_pkg::SlotWidth-1:0] OffM1   = 10'd1;
  localparam logic [dcmd_pkg::SlotWidth-1:0] OffM2   = 10'd2;
  localparam logic [dcmd_pkg::SlotWidth-1:0] OffM3   = 10'd3;
  localparam logic [dcmd_pkg::SlotWidth-1:0] OffSgl  = 10'd4;

  logic [dcmd_pkg::AddrWidth-1:0] start_address_q;
  logic [dcmd_pkg::SlotWidth-1:0] slot_q, slot_d;
  logic                           ignore_q, ignore_d;
  logic [dcmd_pkg::AddrWidth-1:0] base_q, base_d;
  dcmd_pkg::drive_e               m1_q, m1_d, m2_q, m2_d, m3_q, m3_d;
  logic                           single_q, single_d;
  logic                           light_q, light_d;

  logic [dcmd_pkg::SlotWidth-1:0] base_ext;
  logic [dcmd_pkg::SlotWidth-1:0] offset;
  dcmd_pkg::drive_e               code;

  function automatic dcmd_pkg::drive_e drive_code(input logic [7:0] v);
    dcmd_pkg::drive_e c;
    c = dcmd_pkg::DRIVE_STOP;
    if (v > LowMin && v < LowLim) begin
      c = dcmd_pkg::DRIVE_LOW;
    end else if (v > HighMin) begin
      c = dcmd_pkg::DRIVE_HIGH;
    end
    return c;
  endfunction

  assign base_ext = {1'b0, base_q};
  assign offset   = slot_q - base_ext;
  assign code     = drive_code(item_i.rx_byte);

  // Next frame state for the byte in the input register
  always_comb begin
    slot_d   = slot_q;
    ignore_d = ignore_q;
    base_d   = base_q;
    m1_d     = m1_q;
    m2_d     = m2_q;
    m3_d     = m3_q;
    single_d = single_q;
    light_d  = light_q;
    if (item_i.break_seen) begin
      slot_d   = '0;
      ignore_d = 1'b0;
      light_d  = 1'b0;
      base_d   = start_address_q;
    end else if (!ignore_q) begin
      if (slot_q == '0 && item_i.rx_byte != 8'd0) begin
        // nonzero start code: skip the rest of the frame
        ignore_d = 1'b1;
      end else begin
        if (slot_q == base_ext) begin
          light_d = 1'b1;
        end
        if (slot_q >= base_ext) begin
          if (offset == OffM1) begin
            m1_d = code;
          end else if (offset == OffM2) begin
            m2_d = code;
          end else if (offset == OffM3) begin
            m3_d = code;
          end else if (offset == OffSgl) begin
            single_d = item_i.rx_byte > SingleMin;
          end
        end
        if (slot_q != SlotMax) begin
          slot_d = slot_q + 1'b1;
        end
      end
    end
  end

  // Start address register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_address_q <= '0;
    end else if (cfg_we_i) begin
      start_address_q <= cfg_wdata_i;
    end
  end

  // Frame state, updated once per transfer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_q   <= '0;
      ignore_q <= 1'b0;
      base_q   <= '0;
      m1_q     <= dcmd_pkg::DRIVE_STOP;
      m2_q     <= dcmd_pkg::DRIVE_STOP;
      m3_q     <= dcmd_pkg::DRIVE_STOP;
      single_q <= 1'b0;
      light_q  <= 1'b0;
    end else if (advance_i) begin
      slot_q   <= slot_d;
      ignore_q <= ignore_d;
      base_q   <= base_d;
      m1_q     <= m1_d;
      m2_q     <= m2_d;
      m3_q     <= m3_d;
      single_q <= single_d;
      light_q  <= light_d;
    end
  end

  assign result_o.motor1_drive    = m1_d;
  assign result_o.motor2_drive    = m2_d;
  assign result_o.motor3_drive    = m3_d;
  assign result_o.single_motor_on = single_d;
  assign result_o.in_frame_light  = light_d;

endmodule

[rtl/dmx_channel_motor_decoder.sv]
// Channel   Dir  Handshake            Payload
// in        in   in_valid_i/ready_o   in_data_i   (dcmd_pkg::in_t)
// out       out  out_valid_o/ready_i  out_data_o  (dcmd_pkg::out_t)
// cfg       in   cfg_we_i             cfg_wdata_i (start address, 9 bits)
//
// One byte per cycle while results are taken; a byte passes the input
// register, then the result register, before its result is valid and
// can be taken.
// Reset clears the frame state, the start address and both valid flags.
// A stalled result holds the output register; the input register still
// takes one more byte, then in_ready_o drops until the result is taken.
module dmx_channel_motor_decoder (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  dcmd_pkg::in_t                  in_data_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output dcmd_pkg::out_t                 out_data_o,
  input  logic                           cfg_we_i,
  input  logic [dcmd_pkg::AddrWidth-1:0] cfg_wdata_i
);

  dcmd_pkg::in_ctrl_t ctrl;
  dcmd_pkg::in_t      item;
  dcmd_pkg::out_t     result;
  dcmd_pkg::out_t     out_q;
  logic               out_valid_q, out_valid_d;
  logic               out_room;

  assign out_room = ~out_valid_q | out_ready_i;

  dcmd_in_stage u_in_stage (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_room_i (out_room),
    .ctrl_o     (ctrl),
    .item_o     (item)
  );

  dcmd_decode u_decode (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .advance_i   (ctrl.advance),
    .item_i      (item),
    .result_o    (result)
  );

  // Result register valid flag
  always_comb begin
    out_valid_d = out_valid_q;
    if (ctrl.advance) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl.advance) begin
      out_q <= result;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // Input only stalls while a finished result waits downstream
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (ctrl.valid && out_valid_o && !out_ready_i))
    else $error("input stalled without a waiting result");

  // Every item leaving the input register lands in the result register
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl.advance |=> out_valid_o)
    else $error("result lost after advance");

  // A break always clears the in-frame light
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctrl.advance && item.break_seen) |=> !out_data_o.in_frame_light)
    else $error("in-frame light survived a break");

  // Motor code 3 is never driven
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.motor1_drive != 2'd3 &&
                     out_data_o.motor2_drive != 2'd3 &&
                     out_data_o.motor3_drive != 2'd3))
    else $error("undefined motor drive code");

endmodule

[bench/dmx_channel_motor_decoder_test.sv]
// Expected output levels of the decoder, worked out slot by slot
class motor_frame_board;
  localparam int LowFloor    = 15;
  localparam int LowCeil     = 95;
  localparam int HighFloor   = 175;
  localparam int SingleFloor = 128;
  localparam int SlotLimit   = 1023;
  localparam int ShownLimit  = 10;

  // decoder state as the block should hold it
  int                 slot_idx;
  bit                 skip_frame;
  int                 frame_base;
  int                 dip_addr;
  dcmd_pkg::drive_e   bidir [3];
  bit                 single_on;
  bit                 light_on;

  dcmd_pkg::out_t     levels_due [$];
  int                 mismatches;
  int                 results_seen;

  function new();
    slot_idx     = 0;
    skip_frame   = 1'b0;
    frame_base   = 0;
    dip_addr     = 0;
    foreach (bidir[i]) bidir[i] = dcmd_pkg::DRIVE_STOP;
    single_on    = 1'b0;
    light_on     = 1'b0;
    mismatches   = 0;
    results_seen = 0;
  endfunction

  function void set_start_address(logic [8:0] addr);
    dip_addr = int'(addr);
  endfunction

  function dcmd_pkg::drive_e drive_for(logic [7:0] value);
    if (value > LowFloor && value < LowCeil) return dcmd_pkg::DRIVE_LOW;
    if (value > HighFloor) return dcmd_pkg::DRIVE_HIGH;
    return dcmd_pkg::DRIVE_STOP;
  endfunction

  // Apply one accepted slot byte and queue the levels it leaves behind
  function void take_slot(dcmd_pkg::in_t item);
    dcmd_pkg::out_t want;
    int offset;
    if (item.break_seen) begin
      slot_idx   = 0;
      skip_frame = 1'b0;
      light_on   = 1'b0;
      frame_base = dip_addr;
    end else if (!skip_frame) begin
      if (slot_idx == 0 && item.rx_byte != 8'd0) begin
        skip_frame = 1'b1;
      end else begin
        if (slot_idx == frame_base) light_on = 1'b1;
        if (slot_idx >= frame_base) begin
          offset = slot_idx - frame_base;
          if (offset >= 1 && offset <= 3) begin
            bidir[offset-1] = drive_for(item.rx_byte);
          end else if (offset == 4) begin
            single_on = (item.rx_byte > SingleFloor);
          end
        end
        if (slot_idx < SlotLimit) slot_idx++;
      end
    end
    want.motor1_drive    = bidir[0];
    want.motor2_drive    = bidir[1];
    want.motor3_drive    = bidir[2];
    want.single_motor_on = single_on;
    want.in_frame_light  = light_on;
    levels_due.push_back(want);
  endfunction

  // Compare one output transfer against the oldest queued levels
  function void check_levels(dcmd_pkg::out_t got);
    dcmd_pkg::out_t want;
    results_seen++;
    if (levels_due.size() == 0) begin
      mismatches++;
      if (mismatches <= ShownLimit)
        $display("unexpected output transfer %0d: m1=%0d m2=%0d m3=%0d single=%0b light=%0b",
                 results_seen, got.motor1_drive, got.motor2_drive, got.motor3_drive,
                 got.single_motor_on, got.in_frame_light);
      return;
    end
    want = levels_due.pop_front();
    if (got.motor1_drive !== want.motor1_drive ||
        got.motor2_drive !== want.motor2_drive ||
        got.motor3_drive !== want.motor3_drive ||
        got.single_motor_on !== want.single_motor_on ||
        got.in_frame_light !== want.in_frame_light) begin
      mismatches++;
      if (mismatches <= ShownLimit) begin
        $display("levels mismatch at output %0d", results_seen);
        $display("  expected m1=%0d m2=%0d m3=%0d single=%0b light=%0b",
                 want.motor1_drive, want.motor2_drive, want.motor3_drive,
                 want.single_motor_on, want.in_frame_light);
        $display("  actual   m1=%0d m2=%0d m3=%0d single=%0b light=%0b",
                 got.motor1_drive, got.motor2_drive, got.motor3_drive,
                 got.single_motor_on, got.in_frame_light);
      end
    end
  endfunction

  function int waiting();
    return levels_due.size();
  endfunction
endclass

module dmx_channel_motor_decoder_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int HalfPeriod    = 4;
  localparam int ResetCycles   = 11;
  localparam int HoldCycles    = 40;
  localparam int DrainSlack    = 4;
  localparam int StallLimit    = 1000;
  localparam int PhaseCount    = 10;
  localparam int PhaseItems    = 30;
  localparam int HighBaseSlots = 20;

  typedef enum int {
    FRAME_NOISE,
    FRAME_SKIPPED,
    FRAME_CUT,
    FRAME_FULL
  } frame_kind_e;

  logic                           clk_i       = 1'b0;
  logic                           rst_ni      = 1'b0;
  logic                           in_valid_i  = 1'b0;
  logic                           in_ready_o;
  dcmd_pkg::in_t                  in_data_i   = '0;
  logic                           out_valid_o;
  logic                           out_ready_i = 1'b0;
  dcmd_pkg::out_t                 out_data_o;
  logic                           cfg_we_i    = 1'b0;
  logic [dcmd_pkg::AddrWidth-1:0] cfg_wdata_i = '0;

  motor_frame_board sb;
  bit full_rate = 1'b0;
  bit hold_req  = 1'b0;
  int holds_done;
  int transfers_in;
  int counted_items;
  int frames_sent;
  int idle_cycles;

  dmx_channel_motor_decoder uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  always begin
    #HalfPeriod clk_i = 1'b1;
    #HalfPeriod clk_i = 1'b0;
  end

  // Offer one slot byte after a random gap; returns on the falling edge after the transfer
  task automatic send_slot(input logic [7:0] value, input logic brk);
    dcmd_pkg::in_t item;
    int gap;
    item.rx_byte    = value;
    item.break_seen = brk;
    gap = full_rate ? 0 : $urandom_range(0, 9);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= item;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    sb.take_slot(item);
    transfers_in++;
    @(negedge clk_i);
  endtask

  // Stop offering and let every queued result drain out of the pipeline
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (sb.waiting() != 0) @(negedge clk_i);
    repeat (DrainSlack) @(negedge clk_i);
  endtask

  task automatic load_start_address(input logic [8:0] addr);
    cfg_wdata_i <= addr;
    cfg_we_i    <= 1'b1;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    sb.set_start_address(addr);
  endtask

  // Slot values biased toward the drive thresholds
  function automatic logic [7:0] pick_level();
    logic [7:0] thresholds [10] = '{8'd0, 8'd15, 8'd16, 8'd94, 8'd95,
                                    8'd128, 8'd129, 8'd175, 8'd176, 8'd255};
    if ($urandom_range(0, 3) == 0) return thresholds[$urandom_range(0, 9)];
    return 8'($urandom_range(0, 255));
  endfunction

  // One random frame: mostly well formed, some noise, skipped or cut frames
  task automatic send_random_frame(input int base);
    frame_kind_e kind;
    int r;
    int len;
    r = $urandom_range(0, 9);
    kind = (r == 0) ? FRAME_NOISE : (r == 1) ? FRAME_SKIPPED :
           (r == 2) ? FRAME_CUT : FRAME_FULL;
    frames_sent++;
    case (kind)
      FRAME_NOISE: begin
        len = $urandom_range(1, 4);
        repeat (len) send_slot(pick_level(), $urandom_range(0, 7) == 0);
        counted_items += len;
      end
      FRAME_SKIPPED: begin
        send_slot(8'($urandom_range(0, 255)), 1'b1);
        send_slot(8'($urandom_range(1, 255)), 1'b0);
        len = $urandom_range(1, 5);
        repeat (len) send_slot(pick_level(), 1'b0);
        counted_items += 2;
      end
      FRAME_CUT: begin
        send_slot(8'($urandom_range(0, 255)), 1'b1);
        send_slot(8'd0, 1'b0);
        len = $urandom_range(0, base + 3);
        repeat (len) send_slot(pick_level(), 1'b0);
        counted_items += len + 2;
      end
      default: begin
        send_slot(8'($urandom_range(0, 255)), 1'b1);
        send_slot(8'd0, 1'b0);
        len = base + 5 + $urandom_range(0, 3);
        repeat (len) send_slot(pick_level(), 1'b0);
        counted_items += len + 2;
      end
    endcase
  endtask

  // Output side: random stall per result, one long hold-off on request
  initial begin : drain
    int stall;
    wait (rst_ni);
    @(negedge clk_i);
    forever begin
      stall = full_rate ? 0 : $urandom_range(0, 9);
      if (hold_req) begin
        stall    = HoldCycles;
        hold_req = 1'b0;
        holds_done++;
      end
      if (stall > 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      out_ready_i <= 1'b1;
      @(posedge clk_i);
      while (!out_valid_o) @(posedge clk_i);
      sb.check_levels(out_data_o);
      @(negedge clk_i);
    end
  end

  // Watchdog: too long without a transfer on either side
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= StallLimit) begin
      $display("timeout after %0d cycles without a transfer", idle_cycles);
      $display("dmx_channel_motor_decoder test failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin : stimulus
    int addr;
    int r;
    sb = new();
    repeat (ResetCycles) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // base at slot zero: thresholds on every motor, then a skipped frame
    load_start_address(9'd0);
    send_slot(8'hFF, 1'b1);
    send_slot(8'h00, 1'b0);
    send_slot(8'd16, 1'b0);
    send_slot(8'd94, 1'b0);
    send_slot(8'd255, 1'b0);
    send_slot(8'd129, 1'b0);
    send_slot(8'hAA, 1'b0);
    send_slot(8'h00, 1'b1);
    send_slot(8'h00, 1'b0);
    send_slot(8'd15, 1'b0);
    send_slot(8'd95, 1'b0);
    send_slot(8'd176, 1'b0);
    send_slot(8'd128, 1'b0);
    send_slot(8'h5A, 1'b1);
    send_slot(8'h01, 1'b0);
    send_slot(8'h50, 1'b0);
    wait_drained();

    // slots before the base leave the outputs alone
    load_start_address(9'd3);
    send_slot(8'h00, 1'b1);
    send_slot(8'h00, 1'b0);
    send_slot(8'hC8, 1'b0);
    send_slot(8'h14, 1'b0);
    send_slot(8'h00, 1'b0);
    send_slot(8'hFF, 1'b0);
    send_slot(8'd94, 1'b0);

    // random phases, each with its own start address and pacing
    for (int phase = 0; phase < PhaseCount; phase++) begin
      wait_drained();
      r = $urandom_range(0, 7);
      addr = (r == 0) ? 0 : (r == 1) ? $urandom_range(7, 24) : $urandom_range(1, 6);
      load_start_address(9'(addr));
      full_rate = (phase % 4 == 1) || (phase == 2);
      // receiver holds off while the sender keeps pushing at full rate
      if (phase == 2) hold_req = 1'b1;
      counted_items = 0;
      while (counted_items < PhaseItems) send_random_frame(addr);

      // highest base address: a short frame never reaches the base slot
      if (phase == 5) begin
        wait_drained();
        load_start_address(9'd511);
        full_rate = 1'b1;
        send_slot(8'h00, 1'b1);
        send_slot(8'h00, 1'b0);
        repeat (HighBaseSlots) send_slot(pick_level(), 1'b0);
      end
    end
    full_rate = 1'b0;
    wait_drained();

    $display("covered %0d input transfers in %0d random frames, %0d outputs checked,",
             transfers_in, frames_sent, sb.results_seen);
    $display("base addresses 0 to 511, %0d long output hold-off, skipped and cut frames",
             holds_done);
    if (sb.mismatches == 0 && sb.waiting() == 0) begin
      $display("dmx_channel_motor_decoder test passed");
    end else begin
      $display("%0d mismatches, %0d results still expected", sb.mismatches, sb.waiting());
      $display("dmx_channel_motor_decoder test failed");
    end
    $finish;
  end

endmodule
